>>> sv/i2cee_pkg.sv
package i2cee_pkg;

  // action codes carried on s_tuser
  localparam logic [2:0] ACT_MATCH_WR = 3'd0;
  localparam logic [2:0] ACT_MATCH_RD = 3'd1;
  localparam logic [2:0] ACT_WRITE    = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_LOCK     = 3'd4;

  // address phase codes
  localparam logic [1:0] PH_NONE = 2'd0;  // bytes are data
  localparam logic [1:0] PH_LOW  = 2'd1;  // low address byte expected
  localparam logic [1:0] PH_HIGH = 2'd2;  // high address byte expected

  // lock code characters
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_K = 8'h4B;

  localparam int CFG_W = 13;  // mem_size register width
  localparam int DIV_W = 17;  // modulo unit dividend/divisor width
  localparam int PTR_W = 16;

  typedef enum logic [1:0] {
    DIV_ADDR,   // {high byte, low byte}
    DIV_HIGH,   // high byte alone
    DIV_NEXT    // pointer + 1
  } div_src_t;

  typedef struct packed {
    logic     load;       // latch input item, clear result flags
    logic     arm;        // expect two address bytes
    logic     take_high;  // store high address byte
    logic     lock_code;  // run lock code byte
    logic     div_start;
    div_src_t div_src;
    logic     phase_clr;
    logic     ptr_load;   // pointer <= modulo result
    logic     ptr_inc;
    logic     wr;         // store data byte at pointer
    logic     drop;
    logic     rd_take;    // capture read byte
    logic     out_load;
    logic     clr_wr;     // clearing pass write
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic [1:0] phase;
    logic       locked;
    logic       inc_fits;  // pointer + 1 below effective size
    logic       div_done;
    logic       clr_last;
  } dp_sts_t;

endpackage

>>> sv/i2cee_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
module i2cee_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [i2cee_pkg::DIV_W-1:0] dividend,
  input  logic [i2cee_pkg::DIV_W-1:0] divisor,
  output logic                        done,
  output logic [i2cee_pkg::DIV_W-1:0] rem
);

  localparam int W = i2cee_pkg::DIV_W;

  logic         busy;
  logic [4:0]   cnt;
  logic [W-1:0] q;
  logic [W-1:0] r;
  logic [W-1:0] t;
  logic [W-1:0] r_step;

  // r stays below divisor <= 2**(W-1), so the shift fits
  assign t      = {r[W-2:0], q[W-1]};
  assign r_step = (t >= divisor) ? (t - divisor) : t;
  assign rem    = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        r    <= '0;
      end else if (busy) begin
        r   <= r_step;
        q   <= {q[W-2:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/i2cee_dp.sv
module i2cee_dp #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [i2cee_pkg::CFG_W-1:0] cfg_data,
  input  logic [2:0]                  in_act,
  input  logic [7:0]                  in_byte,
  input  i2cee_pkg::dp_cmd_t          cmd,
  output i2cee_pkg::dp_sts_t          sts,
  output logic [15:0]                 out_data
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int W  = i2cee_pkg::DIV_W;
  localparam int PW = i2cee_pkg::PTR_W;
  localparam logic [W-1:0] DEPTH = W'(MEM_DEPTH);
  localparam logic [i2cee_pkg::CFG_W-1:0] SIZE_RST =
    i2cee_pkg::CFG_W'(MEM_DEPTH % (1 << i2cee_pkg::CFG_W));

  typedef enum logic [1:0] {PFX_NONE, PFX_L, PFX_C} pfx_t;

  logic [i2cee_pkg::CFG_W-1:0] mem_size;
  logic [2:0]    act;
  logic [7:0]    byte_r;
  logic [PW-1:0] ptr;
  logic [1:0]    phase;
  logic [7:0]    hi;
  logic          lock;
  pfx_t          pfx;
  logic [7:0]    rd_out;
  logic          dropped;
  logic [AW-1:0] clr_cnt;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;

  logic [W-1:0]  eff;
  logic [W-1:0]  ptr_nx;
  logic          in_range;
  logic [W-1:0]  dividend;
  logic          div_done;
  logic [W-1:0]  rem;

  // effective size: mem_size clamped to 1..MEM_DEPTH
  always_comb begin
    if (mem_size == '0) begin
      eff = W'(1);
    end else if (W'(mem_size) > DEPTH) begin
      eff = DEPTH;
    end else begin
      eff = W'(mem_size);
    end
  end

  assign ptr_nx   = W'(ptr) + W'(1);
  assign in_range = W'(ptr) < DEPTH;

  always_comb begin
    case (cmd.div_src)
      i2cee_pkg::DIV_ADDR: dividend = W'({hi, byte_r});
      i2cee_pkg::DIV_HIGH: dividend = W'(hi);
      i2cee_pkg::DIV_NEXT: dividend = ptr_nx;
      default:             dividend = '0;
    endcase
  end

  i2cee_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (eff),
    .done     (div_done),
    .rem      (rem)
  );

  // store: one write port, one registered read port at the pointer
  assign mem_we   = cmd.clr_wr | (cmd.wr & in_range);
  assign mem_addr = cmd.clr_wr ? clr_cnt : ptr[AW-1:0];
  assign mem_wd   = cmd.clr_wr ? 8'h00 : byte_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= SIZE_RST;
      ptr      <= '0;
      phase    <= i2cee_pkg::PH_NONE;
      hi       <= '0;
      lock     <= 1'b1;
      pfx      <= PFX_NONE;
      clr_cnt  <= '0;
      rd_out   <= '0;
      dropped  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mem_size <= cfg_data;
      end
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load) begin
        act     <= in_act;
        byte_r  <= in_byte;
        rd_out  <= '0;
        dropped <= 1'b0;
      end
      if (cmd.arm) begin
        phase <= i2cee_pkg::PH_HIGH;
      end
      if (cmd.take_high) begin
        hi    <= byte_r;
        phase <= i2cee_pkg::PH_LOW;
      end
      if (cmd.phase_clr) begin
        phase <= i2cee_pkg::PH_NONE;
      end
      if (cmd.ptr_load) begin
        ptr <= rem[PW-1:0];
      end
      if (cmd.ptr_inc) begin
        ptr <= ptr_nx[PW-1:0];
      end
      if (cmd.drop) begin
        dropped <= 1'b1;
      end
      if (cmd.rd_take) begin
        rd_out <= in_range ? mem_q : 8'h00;
      end
      if (cmd.lock_code) begin
        if (byte_r == i2cee_pkg::CH_L) begin
          pfx <= PFX_L;
        end else if (byte_r == i2cee_pkg::CH_C) begin
          pfx <= PFX_C;
        end else begin
          if (byte_r == i2cee_pkg::CH_O && pfx == PFX_L) begin
            lock <= 1'b1;
          end else if (byte_r == i2cee_pkg::CH_K && pfx == PFX_C) begin
            lock <= 1'b0;
          end
          pfx <= PFX_NONE;
        end
      end
    end
  end

  // result register: {pad, write_dropped, locked, read_data}
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {6'b0, dropped, lock, rd_out};
    end
  end

  assign sts.act      = act;
  assign sts.phase    = phase;
  assign sts.locked   = lock;
  assign sts.inc_fits = ptr_nx < eff;
  assign sts.div_done = div_done;
  assign sts.clr_last = clr_cnt == AW'(MEM_DEPTH - 1);

endmodule

>>> sv/i2cee_ctrl.sv
module i2cee_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  i2cee_pkg::dp_sts_t sts,
  output i2cee_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADV,
    S_DIV_OUT,
    S_DIV_RD,
    S_RD_WAIT,
    S_RD_TAKE,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_OUT;
        case (sts.act)
          i2cee_pkg::ACT_MATCH_WR: cmd.arm = 1'b1;
          i2cee_pkg::ACT_WRITE: begin
            if (sts.phase == i2cee_pkg::PH_HIGH) begin
              cmd.take_high = 1'b1;
            end else if (sts.phase == i2cee_pkg::PH_LOW) begin
              cmd.div_start = 1'b1;
              cmd.div_src   = i2cee_pkg::DIV_ADDR;
              cmd.phase_clr = 1'b1;
              state_next    = S_DIV_OUT;
            end else begin
              if (sts.locked) begin
                cmd.drop = 1'b1;
              end else begin
                cmd.wr = 1'b1;
              end
              state_next = S_ADV;
            end
          end
          i2cee_pkg::ACT_READ: begin
            if (sts.phase == i2cee_pkg::PH_LOW) begin
              cmd.div_start = 1'b1;
              cmd.div_src   = i2cee_pkg::DIV_HIGH;
              cmd.phase_clr = 1'b1;
              state_next    = S_DIV_RD;
            end else begin
              state_next = S_RD_WAIT;
            end
          end
          i2cee_pkg::ACT_LOCK: cmd.lock_code = 1'b1;
          default: ;
        endcase
      end
      S_ADV: begin
        if (sts.inc_fits) begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = i2cee_pkg::DIV_NEXT;
          state_next    = S_DIV_OUT;
        end
      end
      S_DIV_OUT: begin
        if (sts.div_done) begin
          cmd.ptr_load = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_DIV_RD: begin
        if (sts.div_done) begin
          cmd.ptr_load = 1'b1;
          state_next   = S_RD_WAIT;
        end
      end
      S_RD_WAIT: state_next = S_RD_TAKE;
      S_RD_TAKE: begin
        cmd.rd_take = 1'b1;
        state_next  = S_ADV;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/i2cee_top_note.sv
// Result check used by the top-level assertions: flags a result whose
// dropped bit is set while the locked bit is clear.
module i2cee_chk (
  input  logic        m_tvalid,
  input  logic [15:0] m_tdata,
  output logic        bad_drop
);

  assign bad_drop = m_tvalid & m_tdata[9] & ~m_tdata[8];

endmodule

>>> sv/i2c_eeprom_slave_with_lock_core.sv
// Byte-wide EEPROM behind an I2C slave byte layer, with a write lock.
// Each input transfer carries one bus event (s_tuser = action) and its byte
// (s_tdata); each one yields exactly one result transfer holding the read
// byte, the lock state after the event and a dropped-write flag. A
// write-direction match arms a two-byte address phase (high byte, then low
// byte); the pointer becomes the address modulo the effective size, i.e.
// mem_size clamped to 1..MEM_DEPTH. Data writes land only while unlocked,
// reads return the byte at the pointer, and both advance it with wrap. Lock
// code pairs 'L','O' lock and 'C','K' unlock; the block comes out of reset
// locked. After reset the store is zeroed by a clearing pass over every
// address, during which s_tready stays low. Items are handled one at a
// time. The bit-serial remainder unit sets the pointer from an address or
// wraps it at the end of the range. A result waits in an output register,
// and the next item is taken in the cycle after that result is loaded.
// mem_size may only be written while no item is in flight.
module i2c_eeprom_slave_with_lock_core #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: mem_size write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_tuser,   // [2:0] action
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_data, [8] locked, [9] write_dropped
);

  i2cee_pkg::dp_cmd_t cmd;
  i2cee_pkg::dp_sts_t sts;
  logic               bad_drop;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  i2cee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2cee_dp #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_act    (s_tuser),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (m_tdata)
  );

  i2cee_chk u_chk (
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .bad_drop (bad_drop)
  );

  // a dropped write can only be reported while locked
  a_drop_locked: assert property (@(posedge clk) disable iff (rst) !bad_drop)
    else $error("write dropped while unlocked");

  // data writes to the store never happen while locked
  a_wr_unlocked: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> !sts.locked)
    else $error("store write while locked");

  // remainder unit does not finish immediately after a start
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("remainder done right after start");

  // no item taken during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !s_tready)
    else $error("input ready during clearing pass");

endmodule

>>> sim/i2cee_monitor.sv
module i2cee_monitor #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          fails,
  output int          pending,
  output int          replies
);

  // m_tdata layout, highest bit first
  typedef struct packed {
    logic [5:0] pad;
    logic       dropped;
    logic       locked;
    logic [7:0] rdata;
  } reply_t;

  typedef enum logic [1:0] {PFX_NONE, PFX_L, PFX_C} prefix_t;

  logic [7:0]       mem [MEM_DEPTH];
  int unsigned      ptr;
  logic [1:0]       phase;
  logic [7:0]       hi_byte;
  logic             lock;
  prefix_t          prefix;
  logic [i2cee_pkg::CFG_W-1:0] size_reg;
  reply_t           reply_q [$];
  int               err_cnt;
  int               seen_cnt;

  // wrap modulus: register clamped to 1..MEM_DEPTH
  function automatic int unsigned span();
    if (size_reg == 0) return 1;
    if (size_reg > MEM_DEPTH) return MEM_DEPTH;
    return 32'(size_reg);
  endfunction

  function automatic reply_t eeprom_apply(logic [2:0] act, logic [7:0] b);
    reply_t r;
    r = '0;
    case (act)
      i2cee_pkg::ACT_MATCH_WR: phase = i2cee_pkg::PH_HIGH;
      i2cee_pkg::ACT_MATCH_RD: ;
      i2cee_pkg::ACT_WRITE: begin
        if (phase == i2cee_pkg::PH_HIGH) begin
          hi_byte = b;
          phase = i2cee_pkg::PH_LOW;
        end else if (phase == i2cee_pkg::PH_LOW) begin
          ptr = {hi_byte, b} % span();
          phase = i2cee_pkg::PH_NONE;
        end else begin
          if (lock) r.dropped = 1'b1;
          else if (ptr < MEM_DEPTH) mem[ptr] = b;
          ptr = (ptr + 1) % span();
        end
      end
      i2cee_pkg::ACT_READ: begin
        // only one address byte given: it alone is the address
        if (phase == i2cee_pkg::PH_LOW) begin
          ptr = hi_byte % span();
          phase = i2cee_pkg::PH_NONE;
        end
        if (ptr < MEM_DEPTH) r.rdata = mem[ptr];
        ptr = (ptr + 1) % span();
      end
      i2cee_pkg::ACT_LOCK: begin
        if (b == i2cee_pkg::CH_L) prefix = PFX_L;
        else if (b == i2cee_pkg::CH_C) prefix = PFX_C;
        else begin
          if (b == i2cee_pkg::CH_O && prefix == PFX_L) lock = 1'b1;
          else if (b == i2cee_pkg::CH_K && prefix == PFX_C) lock = 1'b0;
          prefix = PFX_NONE;
        end
      end
      default: ;
    endcase
    r.locked = lock;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", seen_cnt, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int i = 0; i < MEM_DEPTH; i++) mem[i] = '0;
      ptr = 0;
      phase = i2cee_pkg::PH_NONE;
      hi_byte = '0;
      lock = 1'b1;
      prefix = PFX_NONE;
      size_reg = i2cee_pkg::CFG_W'(MEM_DEPTH);
      reply_q.delete();
    end else begin
      // result first: it always belongs to an earlier item
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        seen_cnt++;
        if (reply_q.size() == 0) begin
          report_mismatch("result with nothing due", int'(got), 0);
        end else begin
          want = reply_q.pop_front();
          if (got.rdata !== want.rdata)
            report_mismatch("read_data", int'(got.rdata), int'(want.rdata));
          if (got.locked !== want.locked)
            report_mismatch("locked", int'(got.locked), int'(want.locked));
          if (got.dropped !== want.dropped)
            report_mismatch("write_dropped", int'(got.dropped), int'(want.dropped));
          if (got.pad !== want.pad)
            report_mismatch("padding", int'(got.pad), int'(want.pad));
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (s_tvalid && s_tready) reply_q.push_back(eeprom_apply(s_tuser, s_tdata));
    end
    fails   <= err_cnt;
    pending <= reply_q.size();
    replies <= seen_cnt;
  end

endmodule

>>> sim/tb.sv
module tb;

  localparam int MEM_DEPTH = 4096;

  // actions the block must ignore
  localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  // sink pacing modes
  typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] data_byte
  logic [2:0]  s_tuser;    // [2:0] action
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [7:0] read_data, [8] locked, [9] write_dropped

  int fails;
  int pending;
  int replies;
  int items_sent;          // items that do something
  int idle_items;          // read matches and undefined actions
  int size_writes;
  int burst_left;
  int addr_hi;
  int addr_lo;
  bit hold_req;
  bit hold_done;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  i2c_eeprom_slave_with_lock_core #(.MEM_DEPTH(MEM_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  i2cee_monitor #(.MEM_DEPTH(MEM_DEPTH)) mon (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fails(fails), .pending(pending), .replies(replies)
  );

  // One item per call. The source runs in bursts; a new burst may open
  // with a gap, and valid stays up across transfers inside a burst.
  task automatic send_item(input logic [2:0] act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act <= i2cee_pkg::ACT_LOCK && act != i2cee_pkg::ACT_MATCH_RD) items_sent++;
    else idle_items++;
  endtask

  // Stop offering and wait until every result due has been taken.
  // The extra edge lets the monitor count the last transfer first.
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mem_size is only touched with nothing in flight
  task automatic set_size(input logic [12:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_writes++;
  endtask

  // Addressed transfer sequence; half the time it revisits the previous
  // address so that reads come back over bytes written earlier.
  task automatic send_address();
    if ($urandom_range(0, 1) != 0) begin
      addr_hi = $urandom_range(0, 255);
      addr_lo = $urandom_range(0, 255);
    end
    send_item(i2cee_pkg::ACT_MATCH_WR, 8'($urandom_range(0, 255)));
    send_item(i2cee_pkg::ACT_WRITE, 8'(addr_hi));
    send_item(i2cee_pkg::ACT_WRITE, 8'(addr_lo));
  endtask

  task automatic run_phase(input int n);
    int start;
    int k;
    int len;
    logic [2:0] op;
    start = items_sent;
    while (items_sent - start < n) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        // full address then a run of data bytes or reads
        send_address();
        len = $urandom_range(1, 8);
        op = ($urandom_range(0, 1) != 0) ? i2cee_pkg::ACT_WRITE : i2cee_pkg::ACT_READ;
        repeat (len) send_item(($urandom_range(0, 3) == 0) ? i2cee_pkg::ACT_READ : op,
                               8'($urandom_range(0, 255)));
      end else if (k < 45) begin
        // one address byte, then read: that byte is the address
        send_item(i2cee_pkg::ACT_MATCH_WR, 8'($urandom_range(0, 255)));
        send_item(i2cee_pkg::ACT_WRITE, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4))
          send_item(i2cee_pkg::ACT_READ, 8'($urandom_range(0, 255)));
      end else if (k < 52) begin
        // read while the high byte is still due, then finish the address
        send_item(i2cee_pkg::ACT_MATCH_WR, 8'($urandom_range(0, 255)));
        send_item(i2cee_pkg::ACT_READ, 8'($urandom_range(0, 255)));
        send_item(i2cee_pkg::ACT_WRITE, 8'($urandom_range(0, 255)));
        send_item(i2cee_pkg::ACT_WRITE, 8'($urandom_range(0, 255)));
        send_item(i2cee_pkg::ACT_READ, 8'($urandom_range(0, 255)));
      end else if (k < 62) begin
        send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_C);
        send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_K);
      end else if (k < 66) begin
        send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_L);
        send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_O);
      end else if (k < 74) begin
        send_item(i2cee_pkg::ACT_MATCH_RD, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4))
          send_item(i2cee_pkg::ACT_READ, 8'($urandom_range(0, 255)));
      end else if (k < 86) begin
        // data bytes and reads at the running pointer
        repeat ($urandom_range(1, 4))
          send_item(($urandom_range(0, 1) != 0) ? i2cee_pkg::ACT_WRITE : i2cee_pkg::ACT_READ,
                    8'($urandom_range(0, 255)));
      end else if (k < 93) begin
        // broken lock codes
        if ($urandom_range(0, 1) != 0)
          send_item(i2cee_pkg::ACT_LOCK,
                    ($urandom_range(0, 1) != 0) ? i2cee_pkg::CH_L : i2cee_pkg::CH_C);
        send_item(i2cee_pkg::ACT_LOCK, 8'($urandom_range(0, 255)));
      end else begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Sink side: random pacing modes, plus one long hold-off on request
  // while the source keeps offering, so the block backs up to its input.
  initial begin : rx_pace
    rx_mode_t mode;
    int left;
    m_tready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        left = $urandom_range(8, 64);
      end
      left--;
      case (mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 1) != 0);
        default:   m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = i2cee_pkg::ACT_MATCH_WR;
    burst_left = 0;
    addr_hi = 0;
    addr_lo = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size. The first transfer waits out the
    // clearing pass. Block starts locked.
    send_item(i2cee_pkg::ACT_READ, 8'h00);      // cleared store reads zero
    send_item(i2cee_pkg::ACT_WRITE, 8'hFF);     // dropped: locked
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_C);
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_K);  // unlocked
    send_item(i2cee_pkg::ACT_MATCH_WR, 8'hFF);
    send_item(i2cee_pkg::ACT_WRITE, 8'hFF);     // address 0xFFFF wraps to the last byte
    send_item(i2cee_pkg::ACT_WRITE, 8'hFF);
    send_item(i2cee_pkg::ACT_WRITE, 8'hA5);     // pointer wraps to zero
    send_item(i2cee_pkg::ACT_WRITE, 8'h00);
    send_item(i2cee_pkg::ACT_MATCH_RD, 8'h00);  // changes nothing
    send_item(i2cee_pkg::ACT_MATCH_WR, 8'h00);
    send_item(i2cee_pkg::ACT_WRITE, 8'h0F);
    send_item(i2cee_pkg::ACT_READ, 8'h00);      // single address byte
    send_item(i2cee_pkg::ACT_MATCH_WR, 8'h00);
    send_item(i2cee_pkg::ACT_READ, 8'h00);      // high byte pending: phase stays armed
    send_item(i2cee_pkg::ACT_WRITE, 8'h0F);
    send_item(i2cee_pkg::ACT_WRITE, 8'hFF);
    send_item(i2cee_pkg::ACT_READ, 8'h00);      // reads back 0xA5
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_L);
    send_item(i2cee_pkg::ACT_LOCK, 8'h58);      // other byte clears the prefix
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_O);  // no prefix: no effect
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_K);
    send_item(ACT_UNDEF_LO, 8'h00);
    send_item(ACT_UNDEF_HI, 8'hFF);
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_L);
    send_item(i2cee_pkg::ACT_LOCK, i2cee_pkg::CH_O);  // locked again

    // Random phases over several sizes. Shrinking leaves the pointer past
    // the new end, which must be used once and then wrap. Zero acts as
    // one, and values over the depth clamp.
    set_size(13'd4096);
    hold_req = 1'b1;
    run_phase(180);
    set_size(13'd1);
    run_phase(180);
    set_size(13'd0);
    run_phase(180);
    set_size(13'd8191);
    run_phase(180);
    set_size(13'd16);
    run_phase(90);
    drain();                              // source waits for every result
    run_phase(90);
    set_size(13'd255);
    run_phase(180);
    set_size(13'd4095);
    run_phase(180);
    set_size(13'($urandom_range(2, 64)));
    run_phase(180);
    set_size(13'($urandom_range(1, 8191)));
    run_phase(180);
    set_size(13'd4096);
    run_phase(180);

    drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d active items and %0d ignored ones across %0d size settings",
             items_sent, idle_items, size_writes);
    $display("Checked %0d results, %0d mismatches, %0d still due", replies, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TIMEOUT with %0d results due", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
